/* hw/rtl/abps_pkg.sv */
package abps_pkg;

   // Fixed field widths
   localparam int DATA_W       = 8;
   localparam int LEN_W        = 5;
   localparam int ALIGN_W      = 8;
   localparam int NEEDLE_REG_W = 64;
   localparam int OFFSET_OUT_W = 32;
   localparam int CSR_ADDR_W   = 2;

   // Parameter defaults
   localparam int NEEDLE_MAX_DEF  = 16;
   localparam int OFFSET_BITS_DEF = 32;

   // Register reset values
   localparam logic [LEN_W-1:0]   NEEDLE_LENGTH_RST = LEN_W'(1);
   localparam logic [ALIGN_W-1:0] ALIGNMENT_RST     = ALIGN_W'(1);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_NEEDLE_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALIGNMENT     = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NEEDLE_LOW    = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NEEDLE_HIGH   = 2'd3;

endpackage

/* hw/rtl/aligned_byte_pattern_search.sv */
// A result is registered in the output register, or in the skid entry while rsp is stalled.
// Throughput: one haystack byte per cycle unless skid is full; the window shift and parallel
// byte compare both complete in the single stage ahead of the result register.
// A two-entry result buffer (output register plus skid) keeps req open until skid is full.
// Reset: synchronous, active high; clears the stream state, the result buffer and
// sets needle_length and alignment to 1, needle bytes to 0.
module aligned_byte_pattern_search
   import abps_pkg::*;
#(
   parameter int NEEDLE_MAX  = NEEDLE_MAX_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // haystack items
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [DATA_W-1:0]       req_tdata,   // [7:0] data_byte
   input  logic                    req_tlast,   // last_byte
   // results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [OFFSET_OUT_W-1:0] rsp_tdata,   // [31:0] match_offset
   output logic                    rsp_tuser,   // [0] found
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [NEEDLE_REG_W-1:0] csr_wdata
);

   localparam int EXT_W = (OFFSET_BITS > OFFSET_OUT_W) ? OFFSET_BITS : OFFSET_OUT_W;

   // configuration registers
   logic [LEN_W-1:0]        needle_length_ff;
   logic [ALIGN_W-1:0]      alignment_ff;
   logic [NEEDLE_REG_W-1:0] needle_low_ff;
   logic [NEEDLE_REG_W-1:0] needle_high_ff;

   // stream state
   logic [DATA_W-1:0]      window_ff [NEEDLE_MAX];
   logic [DATA_W-1:0]      window_in [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0]  marks_ff, marks_in, marks_new;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [ALIGN_W-1:0]     phase_ff, phase_in;
   logic                   reported_ff, reported_in;

   // result buffer
   logic                    out_valid_ff, out_valid_in;
   logic                    out_found_ff, out_found_in;
   logic [OFFSET_OUT_W-1:0] out_offset_ff, out_offset_in;
   logic                    skid_valid_ff, skid_valid_in;
   logic                    skid_found_ff, skid_found_in;
   logic [OFFSET_OUT_W-1:0] skid_offset_ff, skid_offset_in;

   // compare path
   logic                         accept, pop;
   logic [LEN_W-1:0]             n_eff, n_m1;
   logic [ALIGN_W-1:0]           align_eff;
   logic [ALIGN_W:0]             phase_inc;
   logic [2*NEEDLE_REG_W-1:0]    needle_all;
   logic                         mark_sel, bytes_ok, pos_ok, hit;
   logic [OFFSET_BITS-1:0]       offset_full;
   logic [EXT_W-1:0]             offset_ext;
   logic                         res_valid, res_found;
   logic [OFFSET_OUT_W-1:0]      res_offset;

   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = ~skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = out_offset_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= NEEDLE_LENGTH_RST;
         alignment_ff     <= ALIGNMENT_RST;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_ALIGNMENT:     alignment_ff     <= csr_wdata[ALIGN_W-1:0];
            CSR_NEEDLE_LOW:    needle_low_ff    <= csr_wdata;
            CSR_NEEDLE_HIGH:   needle_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective needle length and alignment
   assign n_eff      = (needle_length_ff > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                               : needle_length_ff;
   assign n_m1       = n_eff - LEN_W'(1);
   assign align_eff  = (alignment_ff == '0) ? ALIGN_W'(1) : alignment_ff;
   assign needle_all = {needle_high_ff, needle_low_ff};

   // shifted window with the incoming byte in front
   always_comb begin
      window_in[0] = req_tdata;
      marks_new[0] = (phase_ff == '0);
      for (int k = 1; k < NEEDLE_MAX; k++) begin
         window_in[k] = window_ff[k-1];
         marks_new[k] = marks_ff[k-1];
      end
   end

   // parallel compare against the needle
   always_comb begin
      logic [LEN_W-1:0]  sel;
      logic [DATA_W-1:0] pick;
      mark_sel = 1'b0;
      bytes_ok = 1'b1;
      for (int j = 0; j < NEEDLE_MAX; j++) begin
         if (LEN_W'(j) == n_m1) mark_sel = marks_new[j];
      end
      for (int i = 0; i < NEEDLE_MAX; i++) begin
         sel  = n_m1 - LEN_W'(i);
         pick = '0;
         for (int j = 0; j < NEEDLE_MAX; j++) begin
            if (LEN_W'(j) == sel) pick = window_in[j];
         end
         if ((LEN_W'(i) < n_eff) && (pick != needle_all[DATA_W*i +: DATA_W])) begin
            bytes_ok = 1'b0;
         end
      end
   end

   assign pos_ok      = (pos_ff >= OFFSET_BITS'(n_m1));
   assign hit         = ~reported_ff & (n_eff != '0) & pos_ok & mark_sel & bytes_ok;
   assign offset_full = pos_ff - OFFSET_BITS'(n_m1);
   assign offset_ext  = EXT_W'(offset_full);

   // result of this item: a hit, or not found at the end of the haystack
   assign res_valid  = accept & (hit | (req_tlast & ~reported_ff));
   assign res_found  = hit;
   assign res_offset = hit ? offset_ext[OFFSET_OUT_W-1:0] : '0;

   // next stream state
   assign phase_inc = {1'b0, phase_ff} + (ALIGN_W+1)'(1);

   always_comb begin
      marks_in    = marks_ff;
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_tlast) begin
            marks_in    = '0;
            pos_in      = '0;
            phase_in    = '0;
            reported_in = 1'b0;
         end else begin
            marks_in    = marks_new;
            pos_in      = (pos_ff != '1) ? pos_ff + OFFSET_BITS'(1) : pos_ff;
            phase_in    = (phase_inc >= {1'b0, align_eff}) ? '0 : phase_inc[ALIGN_W-1:0];
            reported_in = reported_ff | hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff    <= '0;
         pos_ff      <= '0;
         phase_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         marks_ff    <= marks_in;
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         reported_ff <= reported_in;
      end
   end

   // window bytes are only read once the position shows they belong to this haystack
   always_ff @(posedge clock) begin
      if (accept) window_ff <= window_in;
   end

   // output register plus skid entry
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_found_in   = out_found_ff;
      out_offset_in  = out_offset_ff;
      skid_valid_in  = skid_valid_ff;
      skid_found_in  = skid_found_ff;
      skid_offset_in = skid_offset_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_found_in  = skid_found_ff;
            out_offset_in = skid_offset_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (out_valid_ff && !pop) begin
            skid_valid_in  = 1'b1;
            skid_found_in  = res_found;
            skid_offset_in = res_offset;
         end else begin
            out_valid_in  = 1'b1;
            out_found_in  = res_found;
            out_offset_in = res_offset;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_found_ff   <= out_found_in;
      out_offset_ff  <= out_offset_in;
      skid_found_ff  <= skid_found_in;
      skid_offset_ff <= skid_offset_in;
   end

endmodule

/* hw/rtl/abps_checker.sv */
module abps_checker
   import abps_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [OFFSET_OUT_W-1:0] rsp_tdata,
   input logic                    rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

   // reset empties the result buffer and opens the input
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result buffer not empty after reset");

   // input only closes while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // not-found results carry a zero offset
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("not-found result with nonzero offset");

endmodule

bind aligned_byte_pattern_search abps_checker u_abps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* bench/aligned_byte_pattern_search_tb.sv */
module aligned_byte_pattern_search_tb;
   import abps_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no item moving on any channel
   localparam int RUN_ITEMS   = 1700;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              last_byte;
   } haystack_item_type;

   typedef struct packed {
      logic                    found;
      logic [OFFSET_OUT_W-1:0] match_offset;
   } search_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DATA_W-1:0]       req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [OFFSET_OUT_W-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [NEEDLE_REG_W-1:0] csr_wdata  = '0;

   aligned_byte_pattern_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the configuration registers
   logic [LEN_W-1:0]        cfg_len   = NEEDLE_LENGTH_RST;
   logic [ALIGN_W-1:0]      cfg_align = ALIGNMENT_RST;
   logic [NEEDLE_REG_W-1:0] cfg_lo    = '0;
   logic [NEEDLE_REG_W-1:0] cfg_hi    = '0;

   // Search state of the current haystack, newest byte at index 0
   logic [DATA_W-1:0]       win_bytes [16] = '{default: '0};
   bit                      win_marks [16] = '{default: 1'b0};
   logic [OFFSET_OUT_W-1:0] byte_pos       = '0;
   logic [ALIGN_W-1:0]      phase_cnt      = '0;
   bit                      match_done     = 1'b0;

   haystack_item_type haystack_bytes [$];
   search_result_type pending_results [$];

   int items_queued = 0;
   int bytes_taken  = 0;
   int fail_count   = 0;
   bit no_idle      = 1'b0;

   int send_gap  = 0;
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DATA_W-1:0] needle_at(input int k);
      if (k < 8)
         return cfg_lo[8*k +: 8];
      else
         return cfg_hi[8*(k-8) +: 8];
   endfunction

   // Advance the search by one haystack byte and queue the result it causes
   task automatic search_byte(input haystack_item_type it);
      int                      n_eff;
      int                      al_eff;
      int                      i;
      logic [OFFSET_OUT_W-1:0] idx;
      bit                      hit;
      n_eff  = (cfg_len > 16) ? 16 : int'(cfg_len);
      al_eff = (cfg_align == 0) ? 1 : int'(cfg_align);
      idx    = byte_pos;
      for (i = 15; i > 0; i--) begin
         win_bytes[i] = win_bytes[i-1];
         win_marks[i] = win_marks[i-1];
      end
      win_bytes[0] = it.data_byte;
      win_marks[0] = (phase_cnt == 0);
      // a phase left over from a larger alignment wraps here
      if (int'(phase_cnt) + 1 >= al_eff)
         phase_cnt = '0;
      else
         phase_cnt = phase_cnt + 1'b1;
      if (byte_pos != '1)
         byte_pos = byte_pos + 1'b1;

      hit = 1'b0;
      if (!match_done && n_eff >= 1 && idx >= OFFSET_OUT_W'(n_eff - 1) && win_marks[n_eff-1]) begin
         hit = 1'b1;
         for (i = 0; i < n_eff; i++) begin
            if (needle_at(i) != win_bytes[n_eff-1-i])
               hit = 1'b0;
         end
      end

      if (hit) begin
         pending_results.push_back('{found: 1'b1, match_offset: idx - OFFSET_OUT_W'(n_eff - 1)});
         match_done = 1'b1;
      end else if (it.last_byte && !match_done) begin
         pending_results.push_back('{found: 1'b0, match_offset: '0});
      end

      if (it.last_byte) begin
         win_bytes  = '{default: '0};
         win_marks  = '{default: 1'b0};
         byte_pos   = '0;
         phase_cnt  = '0;
         match_done = 1'b0;
      end
   endtask

   // Haystack driver
   always @(posedge clock) begin : drive_req
      haystack_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 16) - 1;
            req_tvalid <= 1'b0;
         end else if (haystack_bytes.size() > 0) begin
            nxt = haystack_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.data_byte;
            req_tlast  <= nxt.last_byte;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls plus one long hold-off to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && bytes_taken >= 400) begin
         hold_done = 1'b1;
         hold_left = 399;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: check results against the oldest expectation, then predict
   always @(posedge clock) begin : monitor
      search_result_type oldest;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: found %0d, match_offset %0d", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_tuser !== oldest.found) begin
                  $error("found: expected %0d, got %0d", oldest.found, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== oldest.match_offset) begin
                  $error("match_offset: expected %0d, got %0d", oldest.match_offset, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            search_byte('{data_byte: req_tdata, last_byte: req_tlast});
            bytes_taken <= bytes_taken + 1;
         end
      end
   end

   // Watchdog on channel activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[aligned_byte_pattern_search] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [NEEDLE_REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_NEEDLE_LENGTH: cfg_len   = value[LEN_W-1:0];
         CSR_ALIGNMENT:     cfg_align = value[ALIGN_W-1:0];
         CSR_NEEDLE_LOW:    cfg_lo    = value;
         CSR_NEEDLE_HIGH:   cfg_hi    = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_byte(input logic [DATA_W-1:0] b, input logic last);
      haystack_bytes.push_back('{data_byte: b, last_byte: last});
      items_queued++;
   endtask

   // Block idle: nothing queued, offered or owed, then let the pipeline drain
   task automatic wait_drained(input int extra);
      do
         @(negedge clock);
      while (haystack_bytes.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // One haystack, mostly with the needle planted at an aligned start
   task automatic queue_haystack(input bit close);
      int               hay_len;
      int               plant_at;
      int               n_eff;
      int               al_eff;
      int               kind;
      int               spoil;
      int               i;
      logic [DATA_W-1:0] b;
      n_eff   = (cfg_len > 16) ? 16 : int'(cfg_len);
      al_eff  = (cfg_align == 0) ? 1 : int'(cfg_align);
      hay_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 32);
      kind    = $urandom_range(0, 9);
      // kinds: aligned plant, plant anywhere, spoiled plant, pure noise
      if (kind < 6)
         plant_at = al_eff * $urandom_range(0, hay_len / al_eff);
      else
         plant_at = $urandom_range(0, hay_len);
      spoil = (kind == 8) ? $urandom_range(0, 15) : -1;
      for (i = 0; i < hay_len; i++) begin
         if (kind != 9 && n_eff > 0 && i >= plant_at && i < plant_at + n_eff) begin
            b = needle_at(i - plant_at);
            if (i - plant_at == spoil)
               b = ~b;
         end else if (n_eff > 0 && $urandom_range(0, 1) == 1) begin
            b = needle_at($urandom_range(0, n_eff - 1));
         end else begin
            b = DATA_W'($urandom_range(0, 255));
         end
         add_byte(b, close && (i == hay_len - 1));
      end
   endtask

   initial begin : stimulus
      int                      r;
      int                      k;
      int                      phase_end;
      bit                      pattern;
      logic [LEN_W-1:0]        len;
      logic [ALIGN_W-1:0]      al;
      logic [2*NEEDLE_REG_W-1:0] needle;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset config: needle of one zero byte
      @(negedge clock);
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      wait_drained(4);

      // Zero needle length never matches
      write_reg(CSR_NEEDLE_LENGTH, 0);
      @(negedge clock);
      add_byte(8'h00, 1'b1);
      wait_drained(4);

      // Three-byte needle, zero alignment; short haystack, then bytes past the match
      write_reg(CSR_NEEDLE_LENGTH, 3);
      write_reg(CSR_ALIGNMENT, 0);
      write_reg(CSR_NEEDLE_LOW, 64'h0000_0000_0003_0201);
      @(negedge clock);
      add_byte(8'h01, 1'b0);
      add_byte(8'h02, 1'b1);
      add_byte(8'h09, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h03, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h03, 1'b1);
      wait_drained(4);

      // Length above the maximum, all-ones needle, haystack too short
      write_reg(CSR_NEEDLE_LENGTH, 31);
      write_reg(CSR_NEEDLE_LOW, '1);
      write_reg(CSR_NEEDLE_HIGH, '1);
      @(negedge clock);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hFF, 1'b1);
      wait_drained(4);

      // Alignment shrinks mid-haystack while the phase is past the new value
      write_reg(CSR_NEEDLE_LENGTH, 1);
      write_reg(CSR_ALIGNMENT, 4);
      write_reg(CSR_NEEDLE_LOW, 64'h07);
      @(negedge clock);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h00, 1'b0);
      wait_drained(4);
      write_reg(CSR_ALIGNMENT, 2);
      @(negedge clock);
      add_byte(8'h07, 1'b0);
      add_byte(8'h07, 1'b1);
      wait_drained(4);

      // Random phases; a phase may end inside a haystack
      while (items_queued < RUN_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r == 0)
            len = 0;
         else if (r == 1)
            len = LEN_W'($urandom_range(17, 31));
         else if (r < 5)
            len = 16;
         else
            len = LEN_W'($urandom_range(1, 16));

         r = $urandom_range(0, 11);
         if (r == 0)
            al = 0;
         else if (r == 1)
            al = 8'hFF;
         else if (r < 4)
            al = ALIGN_W'($urandom_range(1, 255));
         else if (r < 8)
            al = 1;
         else
            al = ALIGN_W'($urandom_range(2, 8));

         // two-letter needles give overlapping partial matches
         pattern = ($urandom_range(0, 2) == 0);
         for (k = 0; k < 16; k++)
            needle[8*k +: 8] = pattern ? ($urandom_range(0, 1) ? 8'h41 : 8'h42)
                                       : DATA_W'($urandom_range(0, 255));

         write_reg(CSR_NEEDLE_LENGTH, NEEDLE_REG_W'(len));
         write_reg(CSR_ALIGNMENT, NEEDLE_REG_W'(al));
         write_reg(CSR_NEEDLE_LOW, needle[NEEDLE_REG_W-1:0]);
         write_reg(CSR_NEEDLE_HIGH, needle[2*NEEDLE_REG_W-1:NEEDLE_REG_W]);

         @(negedge clock);
         no_idle = (items_queued >= RUN_ITEMS - 250) || ($urandom_range(0, 3) == 0);
         phase_end = items_queued + $urandom_range(50, 220);
         while (items_queued < phase_end)
            queue_haystack(1'b1);
         if ($urandom_range(0, 3) == 0)
            queue_haystack(1'b0);
         wait_drained(4);
      end

      wait_drained(10);
      if (fail_count == 0)
         $display("[aligned_byte_pattern_search] OK");
      else
         $display("[aligned_byte_pattern_search] ERROR");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/abps_pkg.sv
hw/rtl/aligned_byte_pattern_search.sv
hw/rtl/abps_checker.sv
bench/aligned_byte_pattern_search_tb.sv
